// File: design/sawtc_pkg.sv
// ----------------------------------------------------------------------------
// sawtc_pkg
// Shared types, codes and defaults of the set-associative write-through cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sawtc_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_kind;

    localparam int SETS_DEF       = 128;
    localparam int WAYS_DEF       = 8;
    localparam int LINE_BYTES_DEF = 64;

    localparam t_op OP_READ  = 2'd0;
    localparam t_op OP_WRITE = 2'd1;
    localparam t_op OP_FILL  = 2'd2;

    localparam t_kind KIND_READ  = 2'd0;
    localparam t_kind KIND_FETCH = 2'd1;
    localparam t_kind KIND_WRITE = 2'd2;

    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [15:0] LFSR_SEED = 16'h0001;
    localparam logic [2:0]  MAX_LEN   = 3'd4;

    // galois step, shifted right
    function automatic logic [15:0] lfsr_step(input logic [15:0] x);
        return x[0] ? ((x >> 1) ^ LFSR_MASK) : (x >> 1);
    endfunction

endpackage

`default_nettype wire

// File: design/sawtc_ram.sv
// ----------------------------------------------------------------------------
// sawtc_ram
// Single write port, single read port synchronous ram with lane enables and
// a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sawtc_ram #(
    parameter int DEPTH  = 128,
    parameter int LANES  = 1,
    parameter int LANE_W = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [LANES-1:0]          i_be,
    input  wire logic [LANES*LANE_W-1:0]   i_wdata,
    input  wire logic [AW-1:0]             i_raddr,
    output      logic [LANES*LANE_W-1:0]   o_rdata
);

    logic [LANES*LANE_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int l = 0; l < LANES; l++) begin
                if (i_be[l]) begin
                    mem[i_waddr][l*LANE_W +: LANE_W] <= i_wdata[l*LANE_W +: LANE_W];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/set_assoc_write_through_cache_core.sv
// ----------------------------------------------------------------------------
// set_assoc_write_through_cache_core
// Set-associative write-through cache, no write allocate, random replacement.
//
// One input channel carries reads, writes and fill words returned by memory;
// one output channel carries read data, line fetch requests and memory write
// requests. Both use valid/stall; a word moves when valid is high and stall low.
// Tags with valid bits sit in one ram row per set, line data in a second ram
// whose row holds one word of every way, so a lookup is a ram read and then a
// compare; an access touches one or two words, and the result passes through
// the emit state into the output register. A read miss sends a fetch request,
// takes one fill word per accepted item and then repeats the lookup. Accesses
// that arrive while a fill is open are dropped. After reset the tag ram is
// cleared one set per cycle with the input stalled. A stalled output holds the
// result in its register; the next access is still taken, but its own result
// waits for the register. Geometry parameters are powers of two; WAYS may be
// any value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_write_through_cache_core
    import sawtc_pkg::*;
#(
    parameter int SETS       = SETS_DEF,
    parameter int WAYS       = WAYS_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire t_op         i_op,
    input  wire logic [31:0] i_addr,
    input  wire logic [2:0]  i_len,
    input  wire logic [31:0] i_write_data,
    input  wire logic [31:0] i_fill_word,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      t_kind       o_kind,
    output      logic [31:0] o_data,
    output      logic [31:0] o_mem_addr,
    output      logic [2:0]  o_mem_len
);

    localparam int OFF_W      = $clog2(LINE_BYTES);
    localparam int WORD_W     = OFF_W - 2;
    localparam int LINE_WORDS = LINE_BYTES / 4;
    localparam int SET_W      = $clog2(SETS);
    localparam int TAG_W      = 32 - OFF_W - SET_W;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W      = TAG_W + 1;
    localparam int ROW_W      = WAYS * ENT_W;
    localparam int DROWS      = SETS * LINE_WORDS;
    localparam int DADDR_W    = SET_W + WORD_W;
    localparam int LANES      = WAYS * 4;
    localparam logic [32:0] RECIP =
        33'(((64'd1 << 32) + 64'(WAYS) - 64'd1) / 64'(WAYS));

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;

    logic [2:0]        r_state;
    logic [SET_W-1:0]  r_clr;
    logic              r_op_wr;
    logic [31:0]       r_addr;
    logic [2:0]        r_len;
    logic [31:0]       r_wdata;
    logic              r_seg;
    logic [31:0]       r_acc;
    logic              r_to_fill;
    logic [WORD_W-1:0] r_fill_cnt;
    logic [WAY_W-1:0]  r_victim;
    logic [SET_W-1:0]  r_fill_set;
    logic [TAG_W-1:0]  r_fill_tag;
    logic [ROW_W-1:0]  r_row;
    logic [15:0]       r_lfsr;
    logic [15:0]       r_lfsr_s;
    logic [15:0]       r_lfsr_q;
    logic [WAY_W-1:0]  r_vmod;
    logic              r_out_valid;
    t_kind             r_kind;
    logic [31:0]       r_data;
    logic [31:0]       r_mem_addr;
    logic [2:0]        r_mem_len;
    t_kind             r_res_kind;
    logic [31:0]       r_res_data;
    logic [31:0]       r_res_addr;
    logic [2:0]        r_res_len;

    logic [ROW_W-1:0]     tag_rd;
    logic [WAYS*32-1:0]   data_rd;
    logic                 t_we;
    logic [SET_W-1:0]     t_waddr;
    logic [ROW_W-1:0]     t_wdata;
    logic                 d_we;
    logic [DADDR_W-1:0]   d_waddr;
    logic [LANES-1:0]     d_be;
    logic [WAYS*32-1:0]   d_wdata;

    logic              in_acc;
    logic              fill_acc;
    logic              fill_last;
    logic              slot_free;
    logic [2:0]        in_len;
    logic [31:0]       in_mask;
    logic [29:0]       seg_wa;
    logic [29:0]       look_wa;
    logic [SET_W-1:0]  cmp_set;
    logic [TAG_W-1:0]  cmp_tag;
    logic [WAYS-1:0]   hit_vec;
    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic              has_inv;
    logic [WAY_W-1:0]  first_inv;
    logic [31:0]       hit_word;
    logic [31:0]       n_acc;
    logic [31:0]       wr_word;
    logic [3:0]        wr_be;
    logic [2:0]        end_pos;
    logic              more_seg;
    logic [2:0]        pos;
    logic [48:0]       lfsr_prod;
    logic [15:0]       lfsr_rem;
    logic [15:0]       n_lfsr;

    assign o_in_stall  = !i_rst_n || !(r_state == S_IDLE || r_state == S_FILL);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign fill_acc    = in_acc && (r_state == S_FILL) && (i_op == OP_FILL);
    assign fill_last   = fill_acc && (r_fill_cnt == WORD_W'(LINE_WORDS - 1));
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_data      = r_data;
    assign o_mem_addr  = r_mem_addr;
    assign o_mem_len   = r_mem_len;

    assign in_len  = (i_len > MAX_LEN) ? MAX_LEN : i_len;
    assign seg_wa  = r_addr[31:2] + 30'(r_seg);
    assign look_wa = (r_state == S_IDLE) ? i_addr[31:2] : seg_wa;
    assign cmp_set = seg_wa[WORD_W +: SET_W];
    assign cmp_tag = seg_wa[29 -: TAG_W];
    assign end_pos = {1'b0, r_addr[1:0]} + r_len;
    assign more_seg = !r_seg && (end_pos > MAX_LEN);
    assign n_lfsr  = lfsr_step(r_lfsr);
    assign lfsr_prod = 49'(n_lfsr) * 49'(RECIP);
    assign lfsr_rem  = r_lfsr_s - 16'(20'(r_lfsr_q) * 20'(WAYS));

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            in_mask[k*8 +: 8] = (3'(k) < in_len) ? 8'hFF : 8'h00;
        end
    end

    always_comb begin
        hit_vec   = '0;
        hit       = 1'b0;
        hit_way   = '0;
        has_inv   = 1'b0;
        first_inv = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            hit_vec[w] = tag_rd[w*ENT_W + ENT_W - 1] &&
                         (tag_rd[w*ENT_W +: TAG_W] == cmp_tag);
            if (hit_vec[w]) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!tag_rd[w*ENT_W + ENT_W - 1]) begin
                has_inv   = 1'b1;
                first_inv = WAY_W'(w);
            end
        end
        hit_word = data_rd[hit_way*32 +: 32];
    end

    // bytes of the access that fall in the current word
    always_comb begin
        n_acc   = r_acc;
        wr_word = '0;
        wr_be   = '0;
        pos     = '0;
        for (int k = 0; k < 4; k++) begin
            pos = {1'b0, r_addr[1:0]} + 3'(k);
            if ((pos[2] == r_seg) && (3'(k) < r_len)) begin
                n_acc[k*8 +: 8]         = hit_word[pos[1:0]*8 +: 8];
                wr_word[pos[1:0]*8 +: 8] = r_wdata[k*8 +: 8];
                wr_be[pos[1:0]]          = 1'b1;
            end
        end
    end

    always_comb begin
        d_we    = 1'b0;
        d_waddr = seg_wa[DADDR_W-1:0];
        d_be    = '0;
        d_wdata = {WAYS{wr_word}};
        if (r_state == S_FILL) begin
            d_we    = fill_acc;
            d_waddr = {r_fill_set, r_fill_cnt};
            d_wdata = {WAYS{i_fill_word}};
            for (int w = 0; w < WAYS; w++) begin
                d_be[w*4 +: 4] = (WAY_W'(w) == r_victim) ? 4'hF : 4'h0;
            end
        end else if (r_state == S_CMP && r_op_wr && hit) begin
            d_we = 1'b1;
            for (int w = 0; w < WAYS; w++) begin
                d_be[w*4 +: 4] = (WAY_W'(w) == hit_way) ? wr_be : 4'h0;
            end
        end
    end

    always_comb begin
        t_we    = 1'b0;
        t_waddr = r_fill_set;
        t_wdata = r_row;
        if (r_state == S_CLEAR) begin
            t_we    = 1'b1;
            t_waddr = r_clr;
            t_wdata = '0;
        end else if (fill_last) begin
            t_we = 1'b1;
            for (int w = 0; w < WAYS; w++) begin
                if (WAY_W'(w) == r_victim) begin
                    t_wdata[w*ENT_W +: ENT_W] = {1'b1, r_fill_tag};
                end
            end
        end
    end

    sawtc_ram #(
        .DEPTH  (SETS),
        .LANES  (1),
        .LANE_W (ROW_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_be    (1'b1),
        .i_wdata (t_wdata),
        .i_raddr (look_wa[WORD_W +: SET_W]),
        .o_rdata (tag_rd)
    );

    sawtc_ram #(
        .DEPTH  (DROWS),
        .LANES  (LANES),
        .LANE_W (8)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_be    (d_be),
        .i_wdata (d_wdata),
        .i_raddr (look_wa[DADDR_W-1:0]),
        .o_rdata (data_rd)
    );

    // victim way precomputed from the next lfsr value
    always_ff @(posedge i_clk) begin
        r_lfsr_s <= n_lfsr;
        r_lfsr_q <= lfsr_prod[47:32];
        r_vmod   <= lfsr_rem[WAY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_lfsr      <= LFSR_SEED;
            r_out_valid <= 1'b0;
            r_to_fill   <= 1'b0;
            r_fill_cnt  <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SET_W'(SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc && (i_op == OP_READ || i_op == OP_WRITE)) begin
                        r_op_wr    <= (i_op == OP_WRITE);
                        r_addr     <= i_addr;
                        r_len      <= in_len;
                        r_wdata    <= i_write_data & in_mask;
                        r_seg      <= 1'b0;
                        r_acc      <= '0;
                        r_to_fill  <= 1'b0;
                        r_res_kind <= (i_op == OP_WRITE) ? KIND_WRITE : KIND_READ;
                        r_res_data <= (i_op == OP_WRITE) ? (i_write_data & in_mask) : '0;
                        r_res_addr <= (i_op == OP_WRITE) ? i_addr : '0;
                        r_res_len  <= (i_op == OP_WRITE) ? in_len : '0;
                        r_state    <= (in_len == '0) ? S_EMIT : S_CMP;
                    end
                end
                S_LOOK: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_op_wr) begin
                        if (more_seg) begin
                            r_seg   <= 1'b1;
                            r_state <= S_LOOK;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end else if (hit) begin
                        r_acc <= n_acc;
                        if (more_seg) begin
                            r_seg   <= 1'b1;
                            r_state <= S_LOOK;
                        end else begin
                            r_res_kind <= KIND_READ;
                            r_res_data <= n_acc;
                            r_res_addr <= '0;
                            r_res_len  <= '0;
                            r_to_fill  <= 1'b0;
                            r_state    <= S_EMIT;
                        end
                    end else begin
                        r_fill_set <= cmp_set;
                        r_fill_tag <= cmp_tag;
                        r_row      <= tag_rd;
                        r_fill_cnt <= '0;
                        r_victim   <= has_inv ? first_inv : r_vmod;
                        if (!has_inv) begin
                            r_lfsr <= n_lfsr;
                        end
                        r_res_kind <= KIND_FETCH;
                        r_res_data <= '0;
                        r_res_addr <= {seg_wa[29:WORD_W], {OFF_W{1'b0}}};
                        r_res_len  <= '0;
                        r_to_fill  <= 1'b1;
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= r_res_kind;
                        r_data      <= r_res_data;
                        r_mem_addr  <= r_res_addr;
                        r_mem_len   <= r_res_len;
                        r_state     <= r_to_fill ? S_FILL : S_IDLE;
                    end
                end
                S_FILL: begin
                    if (fill_acc) begin
                        r_fill_cnt <= r_fill_cnt + 1'b1;
                        if (fill_last) begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_one_hit_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> $onehot0(hit_vec))
        else $error("line cached in more than one way");

    a_fill_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |=> (r_state == S_FILL || r_state == S_LOOK))
        else $error("fill left without lookup");

    a_second_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && r_seg) |-> (end_pos > MAX_LEN))
        else $error("second word for an access inside one word");

    a_hit_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && $past(r_state) == S_FILL) |=> hit)
        else $error("miss right after fill");
`endif

endmodule

`default_nettype wire

// File: tb/cache_checker.sv
// ----------------------------------------------------------------------------
// cache_checker
// Watches the access and result channels of the write-through cache, predicts
// every result from its own copy of tags, valid bits, line data and the
// replacement LFSR, and compares each result word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cache_checker
    import sawtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_op         i_op,
    input  logic [31:0] i_addr,
    input  logic [2:0]  i_len,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_fill_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_kind       i_kind,
    input  logic [31:0] i_data,
    input  logic [31:0] i_mem_addr,
    input  logic [2:0]  i_mem_len,
    output int          o_fails,
    output int          o_pending,
    output logic        o_fill_busy,
    output int          o_in_count,
    output int          o_out_count
);

    typedef struct packed {
        t_kind       kind;
        logic [31:0] data;
        logic [31:0] mem_addr;
        logic [2:0]  mem_len;
    } t_result;

    t_result     result_q[$];

    bit          line_ok[1024];
    logic [18:0] line_tag[1024];
    logic [31:0] line_data[16384];
    logic [15:0] victim_lfsr;
    bit          fill_open;
    int          fill_idx;
    int          fill_way;
    logic [31:0] read_addr;
    int          read_len;
    logic [31:0] first_part;
    bit          on_second_line;

    function automatic int find_way(logic [31:0] a);
        int s;
        s = a[12:6];
        for (int w = 0; w < 8; w++)
            if (line_ok[s*8+w] && line_tag[s*8+w] == a[31:13])
                return w;
        return -1;
    endfunction

    function automatic logic [31:0] collect(int s, int w, int off, int n, int pos);
        logic [31:0] v;
        logic [31:0] word;
        v = 0;
        for (int k = 0; k < n; k++) begin
            word = line_data[(s*8+w)*16 + (off+k)/4];
            v |= ((word >> (((off+k)%4)*8)) & 32'hFF) << ((pos+k)*8);
        end
        return v;
    endfunction

    task automatic expect_word(t_kind k, logic [31:0] d, logic [31:0] ma, logic [2:0] ml);
        t_result r;
        r.kind = k;
        r.data = d;
        r.mem_addr = ma;
        r.mem_len = ml;
        result_q.push_back(r);
    endtask

    task automatic open_fill(logic [31:0] la);
        int s;
        int w;
        s = la[12:6];
        w = 0;
        while (w < 8 && line_ok[s*8+w])
            w++;
        if (w == 8) begin
            victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ 16'hB400) : (victim_lfsr >> 1);
            w = victim_lfsr[2:0];
        end
        fill_way = w;
        fill_idx = 0;
        fill_open = 1;
        expect_word(KIND_FETCH, 0, {la[31:6], 6'd0}, 0);
    endtask

    task automatic finish_second();
        int first;
        int w;
        logic [31:0] a2;
        first = 64 - read_addr[5:0];
        a2 = {read_addr[31:6], 6'd0} + 32'd64;
        w = find_way(a2);
        if (w < 0) begin
            on_second_line = 1;
            open_fill(a2);
        end else begin
            expect_word(KIND_READ, first_part | collect(a2[12:6], w, 0, read_len - first, first),
                        0, 0);
        end
    endtask

    task automatic do_read(logic [31:0] a, int n);
        int w;
        int first;
        if (n == 0) begin
            expect_word(KIND_READ, 0, 0, 0);
            return;
        end
        read_addr = a;
        read_len = n;
        w = find_way(a);
        if (w < 0) begin
            on_second_line = 0;
            open_fill(a);
            return;
        end
        first = (a[5:0] + n > 64) ? 64 - a[5:0] : n;
        first_part = collect(a[12:6], w, a[5:0], first, 0);
        if (first == n)
            expect_word(KIND_READ, first_part, 0, 0);
        else
            finish_second();
    endtask

    task automatic do_write(logic [31:0] a, int n, logic [31:0] wd);
        logic [31:0] ba;
        logic [31:0] md;
        logic [31:0] word;
        int w;
        int i;
        md = 0;
        for (int k = 0; k < n; k++) begin
            ba = a + k;
            md |= {24'd0, wd[k*8 +: 8]} << (k*8);
            w = find_way(ba);
            if (w >= 0) begin
                i = (ba[12:6]*8 + w)*16 + ba[5:2];
                word = line_data[i];
                word[ba[1:0]*8 +: 8] = wd[k*8 +: 8];
                line_data[i] = word;
            end
        end
        expect_word(KIND_WRITE, md, a, n);
    endtask

    task automatic take_fill(logic [31:0] fw);
        logic [31:0] la;
        int idx;
        if (!fill_open)
            return;
        la = on_second_line ? {read_addr[31:6], 6'd0} + 32'd64 : read_addr;
        idx = la[12:6]*8 + fill_way;
        line_data[idx*16 + fill_idx] = fw;
        fill_idx++;
        if (fill_idx < 16)
            return;
        fill_idx = 0;
        fill_open = 0;
        line_ok[idx] = 1;
        line_tag[idx] = la[31:13];
        if (on_second_line) begin
            on_second_line = 0;
            finish_second();
        end else begin
            do_read(read_addr, read_len);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        int n;
        if (!i_rst_n) begin
            for (int i = 0; i < 1024; i++)
                line_ok[i] = 0;
            victim_lfsr = 16'h0001;
            fill_open = 0;
            fill_idx = 0;
            fill_way = 0;
            read_addr = 0;
            read_len = 0;
            first_part = 0;
            on_second_line = 0;
            result_q.delete();
            o_fails <= 0;
            o_in_count <= 0;
            o_out_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_out_count <= o_out_count + 1;
                if (result_q.size() == 0) begin
                    if (o_fails < 10)
                        $display("unexpected word: kind %0d data %h addr %h len %0d",
                                 i_kind, i_data, i_mem_addr, i_mem_len);
                    o_fails <= o_fails + 1;
                end else begin
                    want = result_q.pop_front();
                    if (want.kind !== i_kind || want.data !== i_data ||
                        want.mem_addr !== i_mem_addr || want.mem_len !== i_mem_len) begin
                        if (o_fails < 10)
                            $display("mismatch: exp kind %0d data %h addr %h len %0d, got kind %0d data %h addr %h len %0d",
                                     want.kind, want.data, want.mem_addr, want.mem_len,
                                     i_kind, i_data, i_mem_addr, i_mem_len);
                        o_fails <= o_fails + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                o_in_count <= o_in_count + 1;
                n = (i_len > 3'd4) ? 4 : i_len;
                if (i_op == OP_FILL)
                    take_fill(i_fill_word);
                else if (!fill_open && i_op == OP_READ)
                    do_read(i_addr, n);
                else if (!fill_open && i_op == OP_WRITE)
                    do_write(i_addr, n, i_write_data);
            end
        end
        o_pending <= result_q.size();
        o_fill_busy <= fill_open;
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the write-through cache: directed corner accesses, then
// random reads, writes and stray words over a few crowded sets, acting as the
// memory that returns fill words, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import sawtc_pkg::*;

    localparam t_op OP_UNUSED = 2'd3;
    localparam int  WATCH_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_op         i_op;
    logic [31:0] i_addr;
    logic [2:0]  i_len;
    logic [31:0] i_write_data;
    logic [31:0] i_fill_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_kind       o_kind;
    logic [31:0] o_data;
    logic [31:0] o_mem_addr;
    logic [2:0]  o_mem_len;

    int   fails;
    int   pending;
    logic fill_busy;
    int   in_count;
    int   out_count;
    int   in_idle_pct;
    int   out_idle_pct;
    int   quiet_cycles;
    int   last_in;
    int   last_out;

    set_assoc_write_through_cache_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_op(i_op), .i_addr(i_addr), .i_len(i_len),
        .i_write_data(i_write_data), .i_fill_word(i_fill_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_kind(o_kind), .o_data(o_data), .o_mem_addr(o_mem_addr), .o_mem_len(o_mem_len)
    );

    cache_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_op(i_op), .i_addr(i_addr), .i_len(i_len),
        .i_write_data(i_write_data), .i_fill_word(i_fill_word),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_kind(o_kind), .i_data(o_data), .i_mem_addr(o_mem_addr), .i_mem_len(o_mem_len),
        .o_fails(fails), .o_pending(pending), .o_fill_busy(fill_busy),
        .o_in_count(in_count), .o_out_count(out_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < out_idle_pct);

    always @(posedge i_clk) begin
        if (in_count != last_in || out_count != last_out || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        last_in <= in_count;
        last_out <= out_count;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one word on the access channel, returns at the negedge after acceptance
    task automatic send(t_op op, logic [31:0] a, logic [2:0] n, logic [31:0] wd,
                        logic [31:0] fw);
        int seen;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_addr <= a;
        i_len <= n;
        i_write_data <= wd;
        i_fill_word <= fw;
        seen = in_count;
        do @(negedge i_clk); while (in_count == seen);
    endtask

    // drain results, then return the line while a fill is open
    task automatic serve_fills(bit noisy);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        while (fill_busy) begin
            if (noisy && $urandom_range(19) == 0)
                send($urandom_range(1) ? OP_WRITE : OP_READ, $urandom, $urandom,
                     $urandom, $urandom);
            else
                send(OP_FILL, $urandom, $urandom, $urandom, $urandom);
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            while (pending != 0)
                @(negedge i_clk);
        end
    endtask

    task automatic access(t_op op, logic [31:0] a, logic [2:0] n, logic [31:0] wd);
        send(op, a, n, wd, $urandom);
        serve_fills(0);
    endtask

    function automatic logic [31:0] pick_addr();
        logic [18:0] t;
        logic [6:0]  s;
        logic [5:0]  off;
        if ($urandom_range(9) == 0)
            return $urandom;
        case ($urandom_range(3))
            0: t = 19'h7FFFF;
            default: t = $urandom_range(11);
        endcase
        case ($urandom_range(3))
            0: s = 7'd0;
            1: s = 7'd127;
            2: s = 7'd1;
            default: s = $urandom;
        endcase
        off = ($urandom_range(3) == 0) ? 6'd60 + $urandom_range(3) : $urandom;
        return {t, s, off};
    endfunction

    initial begin
        logic [31:0] a;
        int r;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_READ;
        i_addr = 0;
        i_len = 0;
        i_write_data = 0;
        i_fill_word = 0;
        i_out_stall = 1'b0;
        quiet_cycles = 0;
        last_in = 0;
        last_out = 0;
        in_idle_pct = 31;
        out_idle_pct = 81;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners
        send(OP_FILL, 0, 0, 0, 32'hDEAD_BEEF);
        send(OP_UNUSED, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 0);
        access(OP_READ, 32'h0000_0000, 3'd0, 0);
        access(OP_WRITE, 32'h0000_0010, 3'd0, 32'hFFFF_FFFF);
        access(OP_READ, 32'h0000_0004, 3'd4, 0);
        access(OP_READ, 32'h0000_003E, 3'd4, 0);
        access(OP_WRITE, 32'h0000_003D, 3'd4, 32'hA5C3_5A3C);
        access(OP_READ, 32'h0000_003C, 3'd7, 0);
        access(OP_READ, 32'h0000_0102, 3'd1, 0);
        access(OP_READ, 32'h0000_00FF, 3'd2, 0);
        access(OP_READ, 32'h0000_00FF, 3'd5, 0);
        access(OP_WRITE, 32'hFFFF_FFFE, 3'd6, 32'h1234_5678);
        access(OP_READ, 32'hFFFF_FFFD, 3'd4, 0);
        access(OP_READ, 32'hFFFF_FFFD, 3'd3, 0);
        send(OP_READ, 32'h8000_0040, 3'd4, 0, 0);
        send(OP_WRITE, 32'h8000_0040, 3'd4, 32'hFFFF_FFFF, 0);
        send(OP_READ, 32'h0000_0000, 3'd1, 0, 0);
        serve_fills(0);
        for (int i = 0; i < 10; i++)
            access(OP_READ, {i[18:0], 7'd5, 6'd0}, 3'd4, 0);

        // fill words count as input words too
        while (in_count < 900) begin
            if (in_count >= 700) begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end else if (in_count >= 500) begin
                in_idle_pct = 81;
                out_idle_pct = 31;
            end
            a = pick_addr();
            r = $urandom_range(99);
            if (r < 50) begin
                send(OP_READ, a, ($urandom_range(9) == 0) ? $urandom : $urandom_range(4, 1),
                     $urandom, $urandom);
                if (fill_busy)
                    serve_fills(1);
            end else if (r < 90) begin
                send(OP_WRITE, a, ($urandom_range(9) == 0) ? $urandom : $urandom_range(4, 1),
                     $urandom, $urandom);
            end else if (r < 95) begin
                send(OP_FILL, a, $urandom, $urandom, $urandom);
            end else begin
                send(OP_UNUSED, a, $urandom, $urandom, $urandom);
            end
        end

        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
